@@ hdl/f2b_pkg.sv @@
// f2b_pkg: shared types, constants and helpers for the FASTA 2-bit packer.
// No dependencies; used by every module under hdl/.
`timescale 1ns / 1ps

package f2b_pkg;

	// Width of the running packed-byte counter
	localparam int COUNT_WIDTH = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int MAX_WORDS   = 4;

	// Output channel codes
	localparam logic [1:0] CH_BASE   = 2'd0;
	localparam logic [1:0] CH_HEADER = 2'd1;
	localparam logic [1:0] CH_POS    = 2'd2;

	// Characters and masks of interest
	localparam logic [7:0] CHAR_GT   = 8'h3E;
	localparam logic [7:0] CHAR_LF   = 8'h0A;
	localparam logic [7:0] CHAR_NUL  = 8'h00;
	localparam logic [7:0] BASE_MASK = 8'h60;
	localparam logic [7:0] CODE_MASK = 8'h06;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_input;
	} item_word_t;

	typedef struct packed {
		logic [1:0]             channel;
		logic [VALUE_WIDTH-1:0] value;
		logic                   last_of_run;
		logic                   end_of_stream;
	} result_word_t;

	typedef struct packed {
		logic                   in_header;
		logic [1:0]             bases_held;
		logic [5:0]             partial_byte;
		logic [COUNT_WIDTH-1:0] packed_count;
	} pack_state_t;

	typedef result_word_t [MAX_WORDS-1:0] result_list_t;

	// Left-justify the held bases into a byte, zero padded
	function automatic logic [7:0] flush_byte(input logic [1:0] held, input logic [5:0] part);
		logic [7:0] b;
		case (held)
			2'd1:    b = {part[1:0], 6'b0};
			2'd2:    b = {part[3:0], 4'b0};
			2'd3:    b = {part[5:0], 2'b0};
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

@@ hdl/f2b_step.sv @@
// f2b_step: combinational decode of one text byte against the packer state.
// Produces up to four result words and the next state. Uses f2b_pkg.
`timescale 1ns / 1ps

module f2b_step (
	input  f2b_pkg::pack_state_t  st,
	input  f2b_pkg::item_word_t   item,
	output logic [2:0]            word_count,
	output f2b_pkg::result_list_t words,
	output f2b_pkg::pack_state_t  nxt
);

	logic [7:0] c;
	logic [1:0] code;
	logic [2:0] n;

	assign c    = item.text_byte;
	assign code = 2'((c & f2b_pkg::CODE_MASK) >> 1);

	always_comb begin
		n     = 3'd0;
		words = '0;
		nxt   = st;

		// Main byte handling
		if (st.in_header) begin
			words[n[1:0]].channel = f2b_pkg::CH_HEADER;
			if (c == f2b_pkg::CHAR_LF) begin
				words[n[1:0]].value = '0;
				nxt.in_header = 1'b0;
			end else begin
				words[n[1:0]].value = f2b_pkg::VALUE_WIDTH'(c);
			end
			n = n + 3'd1;
		end else if (c == f2b_pkg::CHAR_GT) begin
			// Header start: flush partial byte, position record, then the '>'
			if (st.bases_held != 2'd0) begin
				words[n[1:0]].channel = f2b_pkg::CH_BASE;
				words[n[1:0]].value   = f2b_pkg::VALUE_WIDTH'(
					f2b_pkg::flush_byte(st.bases_held, st.partial_byte));
				n = n + 3'd1;
				nxt.packed_count = st.packed_count + 1'b1;
				nxt.bases_held   = 2'd0;
				nxt.partial_byte = 6'd0;
			end
			words[n[1:0]].channel = f2b_pkg::CH_POS;
			words[n[1:0]].value   = f2b_pkg::VALUE_WIDTH'(nxt.packed_count);
			n = n + 3'd1;
			words[n[1:0]].channel = f2b_pkg::CH_HEADER;
			words[n[1:0]].value   = f2b_pkg::VALUE_WIDTH'(c);
			n = n + 3'd1;
			nxt.in_header = 1'b1;
		end else if ((c & f2b_pkg::BASE_MASK) != 8'h00) begin
			// Base: shift in, emit when four are collected
			if (st.bases_held == 2'd3) begin
				words[n[1:0]].channel = f2b_pkg::CH_BASE;
				words[n[1:0]].value   = f2b_pkg::VALUE_WIDTH'({st.partial_byte, code});
				n = n + 3'd1;
				nxt.packed_count = st.packed_count + 1'b1;
				nxt.bases_held   = 2'd0;
				nxt.partial_byte = 6'd0;
			end else begin
				nxt.partial_byte = {st.partial_byte[3:0], code};
				nxt.bases_held   = st.bases_held + 2'd1;
			end
		end

		// End of stream: terminate header or flush, then back to reset state
		if (item.end_of_input) begin
			if (nxt.in_header) begin
				words[n[1:0]].channel = f2b_pkg::CH_HEADER;
				words[n[1:0]].value   = f2b_pkg::VALUE_WIDTH'(f2b_pkg::CHAR_NUL);
				n = n + 3'd1;
			end else if (nxt.bases_held != 2'd0) begin
				words[n[1:0]].channel = f2b_pkg::CH_BASE;
				words[n[1:0]].value   = f2b_pkg::VALUE_WIDTH'(
					f2b_pkg::flush_byte(nxt.bases_held, nxt.partial_byte));
				n = n + 3'd1;
			end
			if (n != 3'd0) begin
				words[2'(n - 3'd1)].end_of_stream = 1'b1;
			end
			nxt = '0;
		end

		if (n != 3'd0) begin
			words[2'(n - 3'd1)].last_of_run = 1'b1;
		end
	end

	assign word_count = n;

endmodule

@@ hdl/f2b_out_reg.sv @@
// f2b_out_reg: output word register with valid/ready toward the consumer.
// Uses f2b_pkg for the result word type.
`timescale 1ns / 1ps

module f2b_out_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  f2b_pkg::result_word_t load_word,
	output logic                  can_load,
	output logic                  result_valid,
	input  logic                  result_ready,
	output f2b_pkg::result_word_t result
);

	logic                  valid_q;
	f2b_pkg::result_word_t word_q;

	// Slot is free when empty or being drained this cycle
	assign can_load = !valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= load_word;
		end
	end

	assign result_valid = valid_q;
	assign result       = word_q;

endmodule

@@ hdl/fasta_to_2bit_packer.sv @@
// fasta_to_2bit_packer: top level; input register, packer state, word sequencer.
// Depends on f2b_pkg, f2b_step and f2b_out_reg.
//
//  port group     dir  handshake                     word
//  item           in   item_valid / item_ready       f2b_pkg::item_word_t
//  result         out  result_valid / result_ready   f2b_pkg::result_word_t
//
// A byte that yields zero or one word is retired as soon as its word is loaded, so plain
// sequence and header text stream at one byte per cycle while the result side accepts.
// A byte that yields n words (up to four, at a header start or end of stream) holds the
// input register until all n are issued, one word per cycle through the single output register.
// Reset clears the packer state and the valid flags of the input and output registers.
// A stalled result side stops word issue; the input then fills and stalls.
`timescale 1ns / 1ps

module fasta_to_2bit_packer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  f2b_pkg::item_word_t   item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output f2b_pkg::result_word_t result
);

	logic                  s1_valid_q;
	f2b_pkg::item_word_t   item_s1;
	f2b_pkg::pack_state_t  st_q;
	f2b_pkg::pack_state_t  st_nxt;
	logic [1:0]            idx_q;
	logic [2:0]            word_count;
	f2b_pkg::result_list_t words;
	logic                  can_load;
	logic                  out_load;
	logic                  last_word;
	logic                  retire;

	// Decode of the held byte
	f2b_step u_step (
		.st         (st_q),
		.item       (item_s1),
		.word_count (word_count),
		.words      (words),
		.nxt        (st_nxt)
	);

	// Word sequencing: one word per cycle while the output register can load, retire on the last one
	assign last_word  = ({1'b0, idx_q} == (word_count - 3'd1));
	assign out_load   = s1_valid_q && (word_count != 3'd0) && can_load;
	assign retire     = s1_valid_q && ((word_count == 3'd0) || (can_load && last_word));
	assign item_ready = !s1_valid_q || retire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			idx_q      <= 2'd0;
			st_q       <= '0;
		end else begin
			if (item_valid && item_ready) begin
				s1_valid_q <= 1'b1;
			end else if (retire) begin
				s1_valid_q <= 1'b0;
			end
			if (retire) begin
				idx_q <= 2'd0;
				st_q  <= st_nxt;
			end else if (out_load) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// Output register
	f2b_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (out_load),
		.load_word    (words[idx_q]),
		.can_load     (can_load),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

`ifndef NO_ASSERTIONS
	// The word index never runs past the word list of the held byte
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && (word_count != 3'd0)) |-> ({1'b0, idx_q} < word_count))
		else $error("word index beyond word count");

	// A partly issued byte stays in the input register
	a_idx_held: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 2'd0) |-> s1_valid_q)
		else $error("word index set with no byte held");

	// End of input returns the packer to its reset state
	a_eoi_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(retire && item_s1.end_of_input) |=> (st_q == '0))
		else $error("state not cleared after end of input");

	// No bases are held while inside a header
	a_hdr_no_bases: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.in_header |-> (st_q.bases_held == 2'd0))
		else $error("bases held inside header");
`endif

endmodule

@@ bench/f2b_stream_checker.sv @@
// f2b_stream_checker: watches the item and result channels of the FASTA packer,
// predicts every result word from the accepted text bytes and compares in order.
// Depends on f2b_pkg for the word types, channel codes and character constants.
`timescale 1ns / 1ps

module f2b_stream_checker
	import f2b_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	input  logic         item_ready,
	input  item_word_t   item,
	input  logic         result_valid,
	input  logic         result_ready,
	input  result_word_t result,
	output int           waiting,
	output int           mismatches
);

	// Predicted packer state
	logic                   in_hdr;
	logic [1:0]             held;
	logic [5:0]             part;
	logic [COUNT_WIDTH-1:0] byte_count;

	// Words caused by the current text byte, then the queue of words still due
	result_word_t run_words [MAX_WORDS];
	int           run_len;
	result_word_t expected_words [$];

	initial begin
		waiting    = 0;
		mismatches = 0;
		in_hdr     = 1'b0;
		held       = '0;
		part       = '0;
		byte_count = '0;
	end

	task automatic clear_state();
		in_hdr     = 1'b0;
		held       = '0;
		part       = '0;
		byte_count = '0;
	endtask

	task automatic add_word(input logic [1:0] ch, input logic [VALUE_WIDTH-1:0] val);
		result_word_t w;
		w.channel          = ch;
		w.value            = val;
		w.last_of_run      = 1'b0;
		w.end_of_stream    = 1'b0;
		run_words[run_len] = w;
		run_len++;
	endtask

	// Left-justify whatever bases are held into one zero-padded byte
	task automatic flush_held();
		logic [7:0] padded;
		if (held != 2'd0) begin
			padded = {part, 2'b00} << (2 * (3 - held));
			add_word(CH_BASE, VALUE_WIDTH'(padded));
			byte_count++;
			held = '0;
			part = '0;
		end
	endtask

	// Work out the words one accepted text byte causes and queue them
	task automatic pack_text_byte(input item_word_t w);
		logic [7:0] c;
		c       = w.text_byte;
		run_len = 0;
		if (in_hdr) begin
			if (c == CHAR_LF) begin
				add_word(CH_HEADER, '0);
				in_hdr = 1'b0;
			end else begin
				add_word(CH_HEADER, VALUE_WIDTH'(c));
			end
		end else if (c == CHAR_GT) begin
			flush_held();
			add_word(CH_POS, VALUE_WIDTH'(byte_count));
			add_word(CH_HEADER, VALUE_WIDTH'(c));
			in_hdr = 1'b1;
		end else if ((c & BASE_MASK) != 8'h00) begin
			if (held == 2'd3) begin
				add_word(CH_BASE, VALUE_WIDTH'({part, c[2:1]}));
				byte_count++;
				held = '0;
				part = '0;
			end else begin
				part = {part[3:0], c[2:1]};
				held = held + 2'd1;
			end
		end
		// end of input: close an open header or flush, then start over
		if (w.end_of_input) begin
			if (in_hdr)
				add_word(CH_HEADER, '0);
			else
				flush_held();
			if (run_len > 0)
				run_words[run_len-1].end_of_stream = 1'b1;
			clear_state();
		end
		if (run_len > 0)
			run_words[run_len-1].last_of_run = 1'b1;
		for (int i = 0; i < run_len; i++)
			expected_words.push_back(run_words[i]);
	endtask

	task automatic report_mismatch(input string what, input result_word_t exp_w,
			input result_word_t got_w);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch (%s): expected ch=%0d val=%h last=%b eos=%b, got ch=%0d val=%h last=%b eos=%b",
				$realtime, what, exp_w.channel, exp_w.value, exp_w.last_of_run,
				exp_w.end_of_stream, got_w.channel, got_w.value, got_w.last_of_run,
				got_w.end_of_stream);
	endtask

	// Sample both channels at the clock edge, inputs before outputs
	always @(posedge clk) begin
		result_word_t exp_w;
		if (!arst_n) begin
			clear_state();
			expected_words.delete();
		end else begin
			if (item_valid && item_ready)
				pack_text_byte(item);
			if (result_valid && result_ready) begin
				if (expected_words.size() == 0) begin
					report_mismatch("no word due", '0, result);
				end else begin
					exp_w = expected_words.pop_front();
					if (result.channel !== exp_w.channel || result.value !== exp_w.value ||
							result.last_of_run !== exp_w.last_of_run ||
							result.end_of_stream !== exp_w.end_of_stream)
						report_mismatch("field", exp_w, result);
				end
			end
		end
		waiting <= expected_words.size();
	end

endmodule

@@ bench/fasta_to_2bit_packer_test.sv @@
// fasta_to_2bit_packer_test: drives FASTA text into the packer under random idling
// and reports the verdict from the failure count of f2b_stream_checker.
// Depends on f2b_pkg, fasta_to_2bit_packer and f2b_stream_checker.
`timescale 1ns / 1ps

module fasta_to_2bit_packer_test;
	import f2b_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEMS_PER_PHASE = 90;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         item_valid = 1'b0;
	logic         item_ready;
	item_word_t   item = '0;
	logic         result_valid;
	logic         result_ready = 1'b0;
	result_word_t result;

	int waiting;
	int mismatches;
	int src_idle_pct = 35;
	int sink_stall_pct = 65;

	logic [7:0] stream_q [$];

	always #2 clk = ~clk;

	fasta_to_2bit_packer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	f2b_stream_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.waiting      (waiting),
		.mismatches   (mismatches)
	);

	// Receiver stalls at random
	always @(posedge clk)
		result_ready <= ($urandom_range(99) >= sink_stall_pct);

	// Offer one word, with an optional idle gap first; valid stays up between words
	task automatic send_text_byte(input logic [7:0] c, input logic eoi);
		if ($urandom_range(99) < src_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		item_valid <= 1'b1;
		item       <= '{text_byte: c, end_of_input: eoi};
		do @(posedge clk); while (!item_ready);
	endtask

	function automatic logic [7:0] header_char();
		logic [7:0] c;
		if ($urandom_range(99) < 85)
			return 8'($urandom_range(8'h20, 8'h7E));
		do c = 8'($urandom_range(255)); while (c == CHAR_LF);
		return c;
	endfunction

	function automatic logic [7:0] base_char();
		logic [7:0] acgt [8] = '{8'h41, 8'h43, 8'h47, 8'h54, 8'h61, 8'h63, 8'h67, 8'h74};
		case ($urandom_range(0, 9))
			8:       return 8'h4E;
			9:       return 8'($urandom_range(255));
			default: return acgt[$urandom_range(0, 7)];
		endcase
	endfunction

	// Mostly well-formed records with random content, some noise and broken headers
	task automatic build_stream();
		int recs, len, lines;
		stream_q.delete();
		recs = $urandom_range(1, 3);
		repeat (recs) begin
			if ($urandom_range(99) < 80) begin
				stream_q.push_back(CHAR_GT);
				len = $urandom_range(0, 8);
				repeat (len) stream_q.push_back(header_char());
				if ($urandom_range(99) < 90)
					stream_q.push_back(CHAR_LF);
				lines = $urandom_range(0, 3);
				repeat (lines) begin
					len = $urandom_range(0, 14);
					repeat (len) stream_q.push_back(base_char());
					stream_q.push_back(CHAR_LF);
				end
			end else begin
				len = $urandom_range(1, 10);
				repeat (len) stream_q.push_back(8'($urandom_range(255)));
			end
		end
	endtask

	// Cycle counter; ends a hung run
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		item_word_t opening [] = '{
			{CHAR_GT, 1'b0}, {8'hFF, 1'b0}, {CHAR_GT, 1'b0}, {CHAR_NUL, 1'b0},
			{CHAR_LF, 1'b0}, {CHAR_GT, 1'b0}, {CHAR_LF, 1'b0},
			{8'h41, 1'b0}, {8'h63, 1'b0}, {8'h54, 1'b0}, {8'h67, 1'b0},
			{8'h20, 1'b0}, {8'h1F, 1'b0}, {8'h7F, 1'b0}, {8'h80, 1'b0},
			{8'h4E, 1'b0}, {CHAR_GT, 1'b1},
			{8'h47, 1'b0}, {8'h74, 1'b1}, {CHAR_LF, 1'b1},
			{CHAR_GT, 1'b0}, {8'h78, 1'b1}, {CHAR_NUL, 1'b1},
			{8'h43, 1'b0}, {CHAR_GT, 1'b0}
		};
		int sent;
		logic ends;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, header passthrough, back-to-back headers, end cases
		foreach (opening[i])
			send_text_byte(opening[i].text_byte, opening[i].end_of_input);

		// random streams in three idling phases
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0:       begin src_idle_pct = 35; sink_stall_pct = 65; end
				1:       begin src_idle_pct = 65; sink_stall_pct = 35; end
				default: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
			endcase
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				build_stream();
				ends = ($urandom_range(99) < 75);
				foreach (stream_q[i])
					send_text_byte(stream_q[i], ends && (i == stream_q.size() - 1));
				sent += stream_q.size();
			end
		end
		item_valid <= 1'b0;

		// let the checker count the last word, drain, then give a late stray word time
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && waiting == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ files.f @@
hdl/f2b_pkg.sv
hdl/f2b_step.sv
hdl/f2b_out_reg.sv
hdl/fasta_to_2bit_packer.sv
bench/f2b_stream_checker.sv
bench/fasta_to_2bit_packer_test.sv
